FILE: design/tlie_pkg.sv
// ----------------------------------------------------------------------------
// Two-level infix evaluator package
// Operator codes, pending-operation codes, Q16.16 limits and the sequencer
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package tlie_pkg;

  localparam int unsigned QW = 32;   // Q16.16 word width
  localparam int unsigned FW = 16;   // fraction bits

  localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // Operator carried by an input beat.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Pending additive operation.
  localparam logic [1:0] ADD_NONE  = 2'd0;
  localparam logic [1:0] ADD_PLUS  = 2'd1;
  localparam logic [1:0] ADD_MINUS = 2'd2;

  // Pending multiplicative operation.
  localparam logic [1:0] MUL_NONE   = 2'd0;
  localparam logic [1:0] MUL_TIMES  = 2'd1;
  localparam logic [1:0] MUL_DIVIDE = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_FIX  = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

endpackage : tlie_pkg

`default_nettype wire

FILE: design/two_level_infix_evaluator_top.sv
// ----------------------------------------------------------------------------
// Two-level infix evaluator
// Folds a stream of Q16.16 operands into a left-associative expression where
// multiply and divide bind tighter than add and subtract. Multiply and divide
// run bit-serially on a shared 33-bit shift/add datapath.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in_     | input     | in_valid/in_ready   | operand_value, next_operator,
//           |           |                     | last_operand
//   out_    | output    | out_valid/out_ready | result_value, error_flag
//
// An operand with no pending multiply or divide passes through the additive
// fold, then the emit state if it ends the expression. A pending multiply or
// divide adds one serial step per operand bit and one to round and saturate.
// A division by zero or a quotient known to overflow skips the serial pass.
// rst_n is synchronous; it clears the expression state and the output beat.
// A result waiting on out_ready does not block the next input beat; only the
// emit of the following result waits for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_infix_evaluator_top
  import tlie_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic signed [QW-1:0]  in_operand_value,
  input  wire logic [1:0]            in_next_operator,
  input  wire logic                  in_last_operand,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic signed [QW-1:0]  out_result_value,
  output      logic                  out_error_flag
);

  localparam int unsigned CW = $clog2(QW);

  state_t state_r, state_nxt;

  logic [QW-1:0] sum_r, sum_nxt;
  logic [1:0]    add_op_r, add_op_nxt;
  logic [QW-1:0] term_r, term_nxt;
  logic [1:0]    mul_op_r, mul_op_nxt;
  logic          err_r, err_nxt;
  logic [1:0]    op_r, op_nxt;
  logic          last_r, last_nxt;
  logic          neg_r, neg_nxt;
  logic          div_r, div_nxt;
  logic [QW-1:0] hi_r, hi_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic [QW-1:0] opnd_r, opnd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [QW-1:0] out_result_r, out_result_nxt;
  logic          out_error_r, out_error_nxt;

  logic          in_fire;
  logic          out_free;
  logic [QW-1:0] abs_v;
  logic [QW-1:0] abs_t;
  logic          neg_in;
  logic          div_ovf;
  logic [QW-1:0] sat_in;

  // Serial step datapath.
  logic [QW-1:0] addend;
  logic [QW:0]   msum;
  logic [QW:0]   rsh;
  logic          ge;
  logic [QW-1:0] rdiff;

  // Rounding and saturation of the serial result.
  logic [QW+FW-1:0] prod_q;
  logic [QW+FW-1:0] prod_ceil;
  logic             mul_ovf_pos;
  logic             mul_ovf_neg;
  logic             div_ovf_pos;
  logic             div_ovf_neg;
  logic [QW-1:0]    fix_mag;
  logic             fix_ovf;
  logic [QW-1:0]    sat_fix;

  // Additive fold.
  logic [QW:0]   s33;
  logic          sum_ovf;
  logic [QW-1:0] sum_sat;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign abs_v  = in_operand_value[QW-1] ? (~in_operand_value + 1'b1) : in_operand_value;
  assign abs_t  = term_r[QW-1] ? (~term_r + 1'b1) : term_r;
  assign neg_in = term_r[QW-1] ^ in_operand_value[QW-1];
  assign sat_in = neg_in ? Q_MIN : Q_MAX;

  // The quotient reaches 2^32 or more exactly when the integer part of the
  // dividend is at least the divisor.
  assign div_ovf = ({{FW{1'b0}}, abs_t[QW-1:FW]} >= abs_v);

  assign addend = lo_r[0] ? opnd_r : '0;
  assign msum   = {1'b0, hi_r[QW-1:0]} + {1'b0, addend};
  assign rsh    = {hi_r[QW-1:0], lo_r[QW-1]};
  assign ge     = (rsh >= {1'b0, opnd_r});
  // The new remainder is below the divisor, so it fits the low word.
  assign rdiff  = rsh[QW-1:0] - opnd_r;

  // After the multiply pass the magnitude of the product is {hi, lo}.
  assign prod_q    = {hi_r[QW-1:0], lo_r[QW-1:FW]};
  assign prod_ceil = prod_q + {{(QW+FW-1){1'b0}}, |lo_r[FW-1:0]};

  assign mul_ovf_pos = |prod_q[QW+FW-1:QW-1];
  assign mul_ovf_neg = (|prod_ceil[QW+FW-1:QW]) || (prod_ceil[QW-1] && |prod_ceil[QW-2:0]);
  assign div_ovf_pos = lo_r[QW-1];
  assign div_ovf_neg = lo_r[QW-1] && |lo_r[QW-2:0];

  always_comb begin
    if (div_r) begin
      fix_mag = lo_r;
      fix_ovf = neg_r ? div_ovf_neg : div_ovf_pos;
    end else begin
      fix_mag = neg_r ? prod_ceil[QW-1:0] : prod_q[QW-1:0];
      fix_ovf = neg_r ? mul_ovf_neg : mul_ovf_pos;
    end
  end

  assign sat_fix = neg_r ? Q_MIN : Q_MAX;

  always_comb begin
    case (add_op_r)
      ADD_PLUS:  s33 = {sum_r[QW-1], sum_r} + {term_r[QW-1], term_r};
      ADD_MINUS: s33 = {sum_r[QW-1], sum_r} - {term_r[QW-1], term_r};
      default:   s33 = {term_r[QW-1], term_r};
    endcase
  end

  assign sum_ovf = s33[QW] != s33[QW-1];
  assign sum_sat = s33[QW] ? Q_MIN : Q_MAX;

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    add_op_nxt     = add_op_r;
    term_nxt       = term_r;
    mul_op_nxt     = mul_op_r;
    err_nxt        = err_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    neg_nxt        = neg_r;
    div_nxt        = div_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    opnd_nxt       = opnd_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_next_operator;
          last_nxt = in_last_operand;
          neg_nxt  = neg_in;
          cnt_nxt  = '0;
          case (mul_op_r)
            MUL_TIMES: begin
              div_nxt   = 1'b0;
              hi_nxt    = '0;
              lo_nxt    = abs_v;
              opnd_nxt  = abs_t;
              state_nxt = ST_MUL;
            end
            MUL_DIVIDE: begin
              div_nxt = 1'b1;
              if (in_operand_value == '0) begin
                term_nxt  = term_r[QW-1] ? Q_MIN : Q_MAX;
                err_nxt   = 1'b1;
                state_nxt = ST_SUM;
              end else if (div_ovf) begin
                term_nxt  = sat_in;
                err_nxt   = 1'b1;
                state_nxt = ST_SUM;
              end else begin
                // Remainder starts at the integer part; the fraction bits and
                // sixteen zeros shift in from the low word.
                hi_nxt    = {{FW{1'b0}}, abs_t[QW-1:FW]};
                lo_nxt    = {abs_t[FW-1:0], {FW{1'b0}}};
                opnd_nxt  = abs_v;
                state_nxt = ST_DIV;
              end
            end
            default: begin
              term_nxt  = in_operand_value;
              state_nxt = ST_SUM;
            end
          endcase
        end
      end

      ST_MUL: begin
        hi_nxt  = msum[QW:1];
        lo_nxt  = {msum[0], lo_r[QW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          state_nxt = ST_FIX;
        end
      end

      ST_DIV: begin
        hi_nxt  = ge ? rdiff : rsh[QW-1:0];
        lo_nxt  = {lo_r[QW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          state_nxt = ST_FIX;
        end
      end

      ST_FIX: begin
        if (fix_ovf) begin
          term_nxt = sat_fix;
          err_nxt  = 1'b1;
        end else begin
          term_nxt = neg_r ? (~fix_mag + 1'b1) : fix_mag;
        end
        state_nxt = ST_SUM;
      end

      ST_SUM: begin
        if (last_r || (op_r inside {OP_ADD, OP_SUB})) begin
          if (sum_ovf) begin
            sum_nxt = sum_sat;
            err_nxt = 1'b1;
          end else begin
            sum_nxt = s33[QW-1:0];
          end
        end
        if (last_r) begin
          state_nxt = ST_EMIT;
        end else begin
          if (op_r inside {OP_ADD, OP_SUB}) begin
            add_op_nxt = (op_r == OP_ADD) ? ADD_PLUS : ADD_MINUS;
            mul_op_nxt = MUL_NONE;
            term_nxt   = '0;
          end else begin
            mul_op_nxt = (op_r == OP_MUL) ? MUL_TIMES : MUL_DIVIDE;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_EMIT: begin
        // Hold here until the output register can take the result beat.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = sum_r;
          out_error_nxt  = err_r;
          sum_nxt        = '0;
          add_op_nxt     = ADD_NONE;
          term_nxt       = '0;
          mul_op_nxt     = MUL_NONE;
          err_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      add_op_r    <= ADD_NONE;
      term_r      <= '0;
      mul_op_r    <= MUL_NONE;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      add_op_r    <= add_op_nxt;
      term_r      <= term_nxt;
      mul_op_r    <= mul_op_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    neg_r        <= neg_nxt;
    div_r        <= div_nxt;
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    opnd_r       <= opnd_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_error_flag   = out_error_r;

  // A result beat only appears out of the emit state.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result beat raised outside the emit state");

  // An operand with nothing pending goes straight to the additive fold.
  a_plain_operand: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mul_op_r == MUL_NONE) |=> (state_r == ST_SUM))
    else $error("plain operand did not go to the additive fold");

  // A pending multiply starts the serial pass with a cleared bit counter.
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mul_op_r == MUL_TIMES) |=> (state_r == ST_MUL && cnt_r == '0))
    else $error("multiply pass did not start cleanly");

  // Emitting a result returns the expression state to its cleared form.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=>
      (add_op_r == ADD_NONE && mul_op_r == MUL_NONE && !err_r && sum_r == '0))
    else $error("expression state not cleared after emit");

endmodule : two_level_infix_evaluator_top

`default_nettype wire
